FILE: src/irm_pkg.sv
// ----------------------------------------------------------------------------
// I2C register master package
// Shared types and constants for the command front end, the transfer queue
// and the bus sequencer.
// ----------------------------------------------------------------------------
package irm_pkg;

    // Command codes carried in the input transfer.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_PHASE_TICKS    = 1'b1;

    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'h68;
    localparam logic [15:0] PHASE_TICKS_RST    = 16'd10;

    // Depth of the queue between the front end and the sequencer.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Bus sequencer phases.
    typedef enum logic [4:0] {
        PH_IDLE  = 5'd0,
        PH_ST_A  = 5'd1,
        PH_ST_B  = 5'd2,
        PH_ST_C  = 5'd3,
        PH_TX_LO = 5'd4,
        PH_TX_HI = 5'd5,
        PH_SA_LO = 5'd6,
        PH_SA_HI = 5'd7,
        PH_RX_LO = 5'd8,
        PH_RX_HI = 5'd9,
        PH_MA_LO = 5'd10,
        PH_MA_HI = 5'd11,
        PH_SP_A  = 5'd12,
        PH_SP_B  = 5'd13,
        PH_SP_C  = 5'd14,
        PH_RS    = 5'd15
    } phase_t;

    // Which byte is on the wire.
    typedef enum logic [1:0] {
        SEL_ADDR_W = 2'd0,
        SEL_REG    = 2'd1,
        SEL_DATA   = 2'd2,
        SEL_ADDR_R = 2'd3
    } byte_sel_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] read_count;
        logic       sda_in;
    } irm_in_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       read_valid;
        logic [7:0] read_data;
        logic       read_last;
        logic       ack_missing;
        logic       busy_res;
    } irm_out_t;

    // A classified item as it waits in the queue.
    typedef struct packed {
        logic       start;
        logic       is_read;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] count;
        logic       sda_in;
    } irm_item_t;

endpackage

FILE: src/i2c_register_master.sv
// ----------------------------------------------------------------------------
// I2C register master
// Register write and burst read master that steps the SCL and SDA drive by ticks.
// ----------------------------------------------------------------------------
// Each input transfer is one step of the bus: a command (register write or
// burst read) taken while the sequencer is idle loads the transaction, and every
// other transfer is a tick that advances the current bus phase. Each input
// transfer yields exactly one output transfer carrying the SCL and SDA drive
// after that step, a received byte with its last-byte mark when one completes,
// a flag when the slave left SDA high in an acknowledge slot, and the busy
// status. The block takes one input transfer per clock while the queue is not
// full; the sequencer performs one complete step of the bus state machine for
// each queued item it pops. A result passes from the command decoder through
// the two-entry queue and the sequencer step into the output register, and it
// stays in the output register until it is taken, at the next edge at the
// earliest. Either side may stall on its own; the queue and the output
// register absorb the difference. Every bus phase lasts
// phase_ticks transfers (zero counts as one), and the device address is sent
// shifted left with the read/write bit appended. Configuration writes take
// effect at the clock edge where cfg_write is high and should be made while
// no transfer is in flight.
module i2c_register_master (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [irm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  irm_pkg::irm_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output irm_pkg::irm_out_t               out_data
);

    logic               push;
    logic               pop;
    logic               queue_full;
    logic               queue_not_empty;
    irm_pkg::irm_item_t front_item;
    irm_pkg::irm_item_t head_item;

    // Front end: decodes the command and normalizes the read count.
    irm_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .item       (front_item)
    );

    // Queue between the decoder and the sequencer.
    irm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_item)
    );

    // Sequencer: one bus step per queued item, result into the output register.
    irm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (queue_not_empty),
        .item       (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

FILE: src/irm_front.sv
// ----------------------------------------------------------------------------
// I2C register master front end
// Accepts input transfers, decodes the command and normalizes the byte count.
// ----------------------------------------------------------------------------
module irm_front (
    input  logic             in_valid,
    output logic             in_stall,
    input  irm_pkg::irm_in_t in_data,
    input  logic             queue_full,
    output logic             push,
    output irm_pkg::irm_item_t item
);

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        item.start      = (in_data.command == irm_pkg::CMD_WRITE)
                       || (in_data.command == irm_pkg::CMD_READ);
        item.is_read    = (in_data.command == irm_pkg::CMD_READ);
        item.reg_addr   = in_data.reg_addr;
        item.write_data = in_data.write_data;
        // A zero count means one byte.
        item.count      = (in_data.read_count == 8'd0) ? 8'd1 : in_data.read_count;
        item.sda_in     = in_data.sda_in;
    end

endmodule

FILE: src/irm_queue.sv
// ----------------------------------------------------------------------------
// I2C register master transfer queue
// Short FIFO that lets the front end and the sequencer stall independently.
// ----------------------------------------------------------------------------
module irm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  irm_pkg::irm_item_t push_item,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output irm_pkg::irm_item_t head
);

    irm_pkg::irm_item_t                    entry_reg [irm_pkg::QUEUE_DEPTH];
    logic [irm_pkg::QUEUE_PTR_W-1:0]       wr_ptr_reg;
    logic [irm_pkg::QUEUE_PTR_W-1:0]       wr_ptr_next;
    logic [irm_pkg::QUEUE_PTR_W-1:0]       rd_ptr_reg;
    logic [irm_pkg::QUEUE_PTR_W-1:0]       rd_ptr_next;
    logic [irm_pkg::QUEUE_CNT_W-1:0]       count_reg;
    logic [irm_pkg::QUEUE_CNT_W-1:0]       count_next;

    localparam logic [irm_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        irm_pkg::QUEUE_PTR_W'(irm_pkg::QUEUE_DEPTH - 1);
    localparam logic [irm_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
        irm_pkg::QUEUE_CNT_W'(irm_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/irm_back.sv
// ----------------------------------------------------------------------------
// I2C register master bus sequencer
// Advances the bus phases one queued item at a time and registers each result.
// ----------------------------------------------------------------------------
module irm_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [irm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            item_valid,
    input  irm_pkg::irm_item_t              item,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output irm_pkg::irm_out_t               out_data
);

    logic [6:0]          dev_addr_reg;
    logic [15:0]         phase_ticks_reg;

    irm_pkg::phase_t     phase_reg;
    irm_pkg::phase_t     phase_next;
    irm_pkg::byte_sel_t  byte_sel_reg;
    irm_pkg::byte_sel_t  byte_sel_next;
    logic [2:0]          bit_index_reg;
    logic [2:0]          bit_index_next;
    logic [7:0]          shifter_reg;
    logic [7:0]          shifter_next;
    logic [7:0]          bytes_left_reg;
    logic [7:0]          bytes_left_next;
    logic [15:0]         timer_reg;
    logic [15:0]         timer_next;
    logic [7:0]          reg_latch_reg;
    logic [7:0]          reg_latch_next;
    logic [7:0]          data_latch_reg;
    logic [7:0]          data_latch_next;
    logic                is_read_reg;
    logic                is_read_next;

    logic                out_valid_reg;
    irm_pkg::irm_out_t   out_data_reg;
    irm_pkg::irm_out_t   result;

    logic [16:0]         limit;
    logic [16:0]         timer_inc;
    logic                rx_done;
    logic                ack_flag;
    logic                scl_level;
    logic                sda_level;
    logic                nack_level;

    assign pop       = item_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign limit     = (phase_ticks_reg == 16'd0) ? 17'd1 : {1'b0, phase_ticks_reg};
    assign timer_inc = {1'b0, timer_reg} + 17'd1;

    // Next-state and datapath.
    always_comb
    begin
        phase_next      = phase_reg;
        byte_sel_next   = byte_sel_reg;
        bit_index_next  = bit_index_reg;
        shifter_next    = shifter_reg;
        bytes_left_next = bytes_left_reg;
        timer_next      = timer_reg;
        reg_latch_next  = reg_latch_reg;
        data_latch_next = data_latch_reg;
        is_read_next    = is_read_reg;
        rx_done         = 1'b0;
        ack_flag        = 1'b0;
        if (pop)
        begin
            if (phase_reg == irm_pkg::PH_IDLE)
            begin
                if (item.start)
                begin
                    reg_latch_next  = item.reg_addr;
                    data_latch_next = item.write_data;
                    bytes_left_next = item.count;
                    is_read_next    = item.is_read;
                    byte_sel_next   = irm_pkg::SEL_ADDR_W;
                    bit_index_next  = 3'd0;
                    shifter_next    = 8'd0;
                    timer_next      = 16'd0;
                    phase_next      = irm_pkg::PH_ST_A;
                end
            end
            else if (timer_inc < limit)
            begin
                timer_next = timer_inc[15:0];
            end
            else
            begin
                timer_next = 16'd0;
                unique case (phase_reg)
                    irm_pkg::PH_ST_A:  phase_next = irm_pkg::PH_ST_B;
                    irm_pkg::PH_ST_B:  phase_next = irm_pkg::PH_ST_C;
                    irm_pkg::PH_ST_C:
                    begin
                        shifter_next   = {dev_addr_reg, byte_sel_reg == irm_pkg::SEL_ADDR_R};
                        bit_index_next = 3'd0;
                        phase_next     = irm_pkg::PH_TX_LO;
                    end
                    irm_pkg::PH_TX_LO: phase_next = irm_pkg::PH_TX_HI;
                    irm_pkg::PH_TX_HI:
                    begin
                        shifter_next = {shifter_reg[6:0], 1'b0};
                        if (bit_index_reg == 3'd7)
                        begin
                            bit_index_next = 3'd0;
                            phase_next     = irm_pkg::PH_SA_LO;
                        end
                        else
                        begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = irm_pkg::PH_TX_LO;
                        end
                    end
                    irm_pkg::PH_SA_LO: phase_next = irm_pkg::PH_SA_HI;
                    irm_pkg::PH_SA_HI:
                    begin
                        ack_flag       = item.sda_in;
                        bit_index_next = 3'd0;
                        unique case (byte_sel_reg)
                            irm_pkg::SEL_ADDR_W:
                            begin
                                byte_sel_next = irm_pkg::SEL_REG;
                                shifter_next  = reg_latch_reg;
                                phase_next    = irm_pkg::PH_TX_LO;
                            end
                            irm_pkg::SEL_REG:
                            begin
                                if (is_read_reg)
                                begin
                                    byte_sel_next = irm_pkg::SEL_ADDR_R;
                                    phase_next    = irm_pkg::PH_RS;
                                end
                                else
                                begin
                                    byte_sel_next = irm_pkg::SEL_DATA;
                                    shifter_next  = data_latch_reg;
                                    phase_next    = irm_pkg::PH_TX_LO;
                                end
                            end
                            irm_pkg::SEL_DATA: phase_next = irm_pkg::PH_SP_A;
                            default:
                            begin
                                shifter_next = 8'd0;
                                phase_next   = irm_pkg::PH_RX_LO;
                            end
                        endcase
                    end
                    irm_pkg::PH_RX_LO: phase_next = irm_pkg::PH_RX_HI;
                    irm_pkg::PH_RX_HI:
                    begin
                        shifter_next = {shifter_reg[6:0], item.sda_in};
                        if (bit_index_reg == 3'd7)
                        begin
                            rx_done        = 1'b1;
                            bit_index_next = 3'd0;
                            phase_next     = irm_pkg::PH_MA_LO;
                        end
                        else
                        begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = irm_pkg::PH_RX_LO;
                        end
                    end
                    irm_pkg::PH_MA_LO: phase_next = irm_pkg::PH_MA_HI;
                    irm_pkg::PH_MA_HI:
                    begin
                        if (bytes_left_reg <= 8'd1)
                        begin
                            bytes_left_next = 8'd0;
                            phase_next      = irm_pkg::PH_SP_A;
                        end
                        else
                        begin
                            bytes_left_next = bytes_left_reg - 8'd1;
                            shifter_next    = 8'd0;
                            bit_index_next  = 3'd0;
                            phase_next      = irm_pkg::PH_RX_LO;
                        end
                    end
                    irm_pkg::PH_SP_A:  phase_next = irm_pkg::PH_SP_B;
                    irm_pkg::PH_SP_B:  phase_next = irm_pkg::PH_SP_C;
                    irm_pkg::PH_RS:    phase_next = irm_pkg::PH_ST_A;
                    default:           phase_next = irm_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // Line levels after the step.
    assign nack_level = (bytes_left_next <= 8'd1);

    always_comb
    begin
        unique case (phase_next)
            irm_pkg::PH_ST_B:  begin scl_level = 1'b1; sda_level = 1'b0;            end
            irm_pkg::PH_ST_C:  begin scl_level = 1'b0; sda_level = 1'b0;            end
            irm_pkg::PH_TX_LO: begin scl_level = 1'b0; sda_level = shifter_next[7]; end
            irm_pkg::PH_TX_HI: begin scl_level = 1'b1; sda_level = shifter_next[7]; end
            irm_pkg::PH_SA_LO: begin scl_level = 1'b0; sda_level = 1'b1;            end
            irm_pkg::PH_RX_LO: begin scl_level = 1'b0; sda_level = 1'b1;            end
            irm_pkg::PH_MA_LO: begin scl_level = 1'b0; sda_level = nack_level;      end
            irm_pkg::PH_MA_HI: begin scl_level = 1'b1; sda_level = nack_level;      end
            irm_pkg::PH_SP_A:  begin scl_level = 1'b0; sda_level = 1'b0;            end
            irm_pkg::PH_SP_B:  begin scl_level = 1'b1; sda_level = 1'b0;            end
            irm_pkg::PH_RS:    begin scl_level = 1'b0; sda_level = 1'b1;            end
            default:           begin scl_level = 1'b1; sda_level = 1'b1;            end
        endcase
    end

    always_comb
    begin
        result.scl_out     = scl_level;
        result.sda_out     = sda_level;
        result.read_valid  = rx_done;
        result.read_data   = rx_done ? shifter_next : 8'd0;
        result.read_last   = rx_done && (bytes_left_reg <= 8'd1);
        result.ack_missing = ack_flag;
        result.busy_res    = (phase_next != irm_pkg::PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg    <= irm_pkg::DEVICE_ADDRESS_RST;
            phase_ticks_reg <= irm_pkg::PHASE_TICKS_RST;
            phase_reg       <= irm_pkg::PH_IDLE;
            byte_sel_reg    <= irm_pkg::SEL_ADDR_W;
            bit_index_reg   <= 3'd0;
            shifter_reg     <= 8'd0;
            bytes_left_reg  <= 8'd0;
            timer_reg       <= 16'd0;
            reg_latch_reg   <= 8'd0;
            data_latch_reg  <= 8'd0;
            is_read_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    irm_pkg::CFG_DEVICE_ADDRESS: dev_addr_reg    <= cfg_data[6:0];
                    irm_pkg::CFG_PHASE_TICKS:    phase_ticks_reg <= cfg_data;
                    default:                     phase_ticks_reg <= phase_ticks_reg;
                endcase
            end
            phase_reg      <= phase_next;
            byte_sel_reg   <= byte_sel_next;
            bit_index_reg  <= bit_index_next;
            shifter_reg    <= shifter_next;
            bytes_left_reg <= bytes_left_next;
            timer_reg      <= timer_next;
            reg_latch_reg  <= reg_latch_next;
            data_latch_reg <= data_latch_next;
            is_read_reg    <= is_read_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= result;
        end
    end

endmodule

FILE: bench/tb_i2c_register_master.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C register master testbench
// Drives register writes, burst reads and tick transfers into the block. A
// scoreboard steps its own copy of the bus sequencer for every accepted
// transfer and checks each output transfer, field by field, in order.
// ----------------------------------------------------------------------------
module tb_i2c_register_master;

    // The command field is two bits wide; the fourth code acts as a tick.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Generous bound on the whole run, far above the slowest correct run.
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    // ------------------------------------------------------------------------
    // Scoreboard: a cycle-free copy of the bus sequencer. Every accepted input
    // transfer advances the copy by one step and queues the output transfer
    // that step must produce.
    // ------------------------------------------------------------------------
    class i2c_step_board;
        irm_pkg::phase_t    phase;
        irm_pkg::byte_sel_t sel;
        logic [2:0]         bit_idx;
        logic [7:0]         shifter;
        logic [7:0]         bytes_left;
        logic [7:0]         reg_hold;
        logic [7:0]         data_hold;
        logic [15:0]        timer;
        logic               read_xfer;
        logic [6:0]         dev_addr;
        logic [15:0]        phase_ticks;
        irm_pkg::irm_out_t  expected_steps[$];
        int                 mismatches;

        function new();
            phase       = irm_pkg::PH_IDLE;
            sel         = irm_pkg::SEL_ADDR_W;
            bit_idx     = '0;
            shifter     = '0;
            bytes_left  = '0;
            reg_hold    = '0;
            data_hold   = '0;
            timer       = '0;
            read_xfer   = 1'b0;
            dev_addr    = irm_pkg::DEVICE_ADDRESS_RST;
            phase_ticks = irm_pkg::PHASE_TICKS_RST;
            mismatches  = 0;
        endfunction

        function void load_setting(logic idx, logic [15:0] value);
            if (idx == irm_pkg::CFG_DEVICE_ADDRESS)
                dev_addr = value[6:0];
            else
                phase_ticks = value;
        endfunction

        function bit seq_busy();
            return phase != irm_pkg::PH_IDLE;
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        // One bus step: either load a new transaction (idle only) or count
        // down the current phase and move to the next one.
        function irm_pkg::irm_out_t predict_step(irm_pkg::irm_in_t it);
            irm_pkg::irm_out_t r;
            int                lim;
            logic              bit_now;
            logic              nack;
            r   = '0;
            lim = (phase_ticks == 16'd0) ? 1 : int'(phase_ticks);
            if (phase == irm_pkg::PH_IDLE)
            begin
                if (it.command == irm_pkg::CMD_WRITE || it.command == irm_pkg::CMD_READ)
                begin
                    reg_hold   = it.reg_addr;
                    data_hold  = it.write_data;
                    bytes_left = (it.read_count == 8'd0) ? 8'd1 : it.read_count;
                    read_xfer  = (it.command == irm_pkg::CMD_READ);
                    sel        = irm_pkg::SEL_ADDR_W;
                    bit_idx    = '0;
                    shifter    = '0;
                    timer      = '0;
                    phase      = irm_pkg::PH_ST_A;
                end
            end
            else if (int'(timer) + 1 < lim)
            begin
                timer = timer + 16'd1;
            end
            else
            begin
                timer = '0;
                unique case (phase)
                    irm_pkg::PH_ST_A: phase = irm_pkg::PH_ST_B;
                    irm_pkg::PH_ST_B: phase = irm_pkg::PH_ST_C;
                    irm_pkg::PH_ST_C:
                    begin
                        shifter = {dev_addr, sel == irm_pkg::SEL_ADDR_R};
                        bit_idx = '0;
                        phase   = irm_pkg::PH_TX_LO;
                    end
                    irm_pkg::PH_TX_LO: phase = irm_pkg::PH_TX_HI;
                    irm_pkg::PH_TX_HI:
                    begin
                        shifter = shifter << 1;
                        if (bit_idx == 3'd7)
                        begin
                            bit_idx = '0;
                            phase   = irm_pkg::PH_SA_LO;
                        end
                        else
                        begin
                            bit_idx = bit_idx + 3'd1;
                            phase   = irm_pkg::PH_TX_LO;
                        end
                    end
                    irm_pkg::PH_SA_LO: phase = irm_pkg::PH_SA_HI;
                    irm_pkg::PH_SA_HI:
                    begin
                        r.ack_missing = it.sda_in;
                        bit_idx = '0;
                        if (sel == irm_pkg::SEL_ADDR_W)
                        begin
                            sel     = irm_pkg::SEL_REG;
                            shifter = reg_hold;
                            phase   = irm_pkg::PH_TX_LO;
                        end
                        else if (sel == irm_pkg::SEL_REG)
                        begin
                            if (read_xfer)
                            begin
                                sel   = irm_pkg::SEL_ADDR_R;
                                phase = irm_pkg::PH_RS;
                            end
                            else
                            begin
                                sel     = irm_pkg::SEL_DATA;
                                shifter = data_hold;
                                phase   = irm_pkg::PH_TX_LO;
                            end
                        end
                        else if (sel == irm_pkg::SEL_DATA)
                        begin
                            phase = irm_pkg::PH_SP_A;
                        end
                        else
                        begin
                            shifter = '0;
                            phase   = irm_pkg::PH_RX_LO;
                        end
                    end
                    irm_pkg::PH_RX_LO: phase = irm_pkg::PH_RX_HI;
                    irm_pkg::PH_RX_HI:
                    begin
                        shifter = {shifter[6:0], it.sda_in};
                        if (bit_idx == 3'd7)
                        begin
                            r.read_valid = 1'b1;
                            r.read_data  = shifter;
                            r.read_last  = (bytes_left <= 8'd1);
                            bit_idx      = '0;
                            phase        = irm_pkg::PH_MA_LO;
                        end
                        else
                        begin
                            bit_idx = bit_idx + 3'd1;
                            phase   = irm_pkg::PH_RX_LO;
                        end
                    end
                    irm_pkg::PH_MA_LO: phase = irm_pkg::PH_MA_HI;
                    irm_pkg::PH_MA_HI:
                    begin
                        if (bytes_left <= 8'd1)
                        begin
                            bytes_left = '0;
                            phase      = irm_pkg::PH_SP_A;
                        end
                        else
                        begin
                            bytes_left = bytes_left - 8'd1;
                            shifter    = '0;
                            bit_idx    = '0;
                            phase      = irm_pkg::PH_RX_LO;
                        end
                    end
                    irm_pkg::PH_SP_A: phase = irm_pkg::PH_SP_B;
                    irm_pkg::PH_SP_B: phase = irm_pkg::PH_SP_C;
                    irm_pkg::PH_RS:   phase = irm_pkg::PH_ST_A;
                    default:          phase = irm_pkg::PH_IDLE;
                endcase
            end

            // Line drive after the step; released lines read as 1.
            bit_now = shifter[7];
            nack    = (bytes_left <= 8'd1);
            r.scl_out = 1'b1;
            r.sda_out = 1'b1;
            unique case (phase)
                irm_pkg::PH_ST_B:  begin r.scl_out = 1'b1; r.sda_out = 1'b0;    end
                irm_pkg::PH_ST_C:  begin r.scl_out = 1'b0; r.sda_out = 1'b0;    end
                irm_pkg::PH_TX_LO: begin r.scl_out = 1'b0; r.sda_out = bit_now; end
                irm_pkg::PH_TX_HI: begin r.scl_out = 1'b1; r.sda_out = bit_now; end
                irm_pkg::PH_SA_LO: begin r.scl_out = 1'b0; r.sda_out = 1'b1;    end
                irm_pkg::PH_RX_LO: begin r.scl_out = 1'b0; r.sda_out = 1'b1;    end
                irm_pkg::PH_MA_LO: begin r.scl_out = 1'b0; r.sda_out = nack;    end
                irm_pkg::PH_MA_HI: begin r.scl_out = 1'b1; r.sda_out = nack;    end
                irm_pkg::PH_SP_A:  begin r.scl_out = 1'b0; r.sda_out = 1'b0;    end
                irm_pkg::PH_SP_B:  begin r.scl_out = 1'b1; r.sda_out = 1'b0;    end
                irm_pkg::PH_RS:    begin r.scl_out = 1'b0; r.sda_out = 1'b1;    end
                default:           begin r.scl_out = 1'b1; r.sda_out = 1'b1;    end
            endcase
            r.busy_res = (phase != irm_pkg::PH_IDLE);
            return r;
        endfunction

        function void accept_step(irm_pkg::irm_in_t it);
            expected_steps.push_back(predict_step(it));
        endfunction

        function void field_check(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_step(irm_pkg::irm_out_t got);
            irm_pkg::irm_out_t want;
            if (expected_steps.size() == 0)
            begin
                $display("%0t: unexpected output transfer, expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_steps.pop_front();
            field_check("scl_out",     8'(want.scl_out),     8'(got.scl_out));
            field_check("sda_out",     8'(want.sda_out),     8'(got.sda_out));
            field_check("read_valid",  8'(want.read_valid),  8'(got.read_valid));
            field_check("read_data",   want.read_data,       got.read_data);
            field_check("read_last",   8'(want.read_last),   8'(got.read_last));
            field_check("ack_missing", 8'(want.ack_missing), 8'(got.ack_missing));
            field_check("busy_res",    8'(want.busy_res),    8'(got.busy_res));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test and the signals around it. Every input starts at a
    // known value.
    // ------------------------------------------------------------------------
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_write = 1'b0;
    logic                           cfg_index = irm_pkg::CFG_DEVICE_ADDRESS;
    logic [irm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    irm_pkg::irm_in_t               in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    irm_pkg::irm_out_t              out_data;

    i2c_register_master u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    i2c_step_board sb = new();

    // Idling mix, in percent per cycle, changed from phase to phase.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // A request for one long receiver hold-off. The receiver process counts
    // the stretch down on its own while the sender keeps offering transfers,
    // so the queue and the output register fill and the input side stalls.
    bit hold_request = 1'b0;
    int hold_left    = 0;

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Output transfers are taken at the edge where out_valid is high and
    // out_stall is low; both are read before this edge updates them.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.compare_step(out_data);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Offer one input transfer and wait for the edge that takes it. Each
    // cycle before the offer is idle with the sender's idling chance. The
    // scoreboard is told at the taking edge, so the next transfer can be
    // chosen from the sequencer state the block now holds.
    task automatic send_step(input irm_pkg::irm_in_t step);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= step;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.accept_step(step);
    endtask

    // A tick carries random content in the fields that it does not use; the
    // SDA level is what the slave would drive in this step.
    function automatic irm_pkg::irm_in_t make_tick(logic [1:0] code);
        irm_pkg::irm_in_t s;
        s.command    = code;
        s.reg_addr   = 8'($urandom_range(255));
        s.write_data = 8'($urandom_range(255));
        s.read_count = 8'($urandom_range(255));
        s.sda_in     = ($urandom_range(99) < 40);
        return s;
    endfunction

    function automatic irm_pkg::irm_in_t make_command(logic [1:0] code, logic [7:0] reg_no,
                                                      logic [7:0] value, logic [7:0] count);
        irm_pkg::irm_in_t s;
        s.command    = code;
        s.reg_addr   = reg_no;
        s.write_data = value;
        s.read_count = count;
        s.sda_in     = 1'($urandom_range(1));
        return s;
    endfunction

    task automatic tick_until_idle();
        while (sb.seq_busy())
            send_step(make_tick(irm_pkg::CMD_TICK));
    endtask

    task automatic run_transaction(input logic [1:0] code, input logic [7:0] reg_no,
                                   input logic [7:0] value, input logic [7:0] count);
        send_step(make_command(code, reg_no, value, count));
        tick_until_idle();
    endtask

    // Stop offering, let every expected output transfer arrive, then allow
    // the pipeline a little slack before touching the registers.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_setting(input logic idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.load_setting(idx, value);
        @(posedge clk);
    endtask

    // Mostly well-formed traffic: start a transaction when the sequencer is
    // idle and tick it to the end. A few transfers are noise: the unused
    // code, or a command thrown in while busy, which the block treats as a tick.
    function automatic irm_pkg::irm_in_t next_random_step();
        int roll;
        roll = $urandom_range(99);
        if (!sb.seq_busy())
        begin
            if (roll < 85)
                return make_command(($urandom_range(1) != 0) ? irm_pkg::CMD_READ
                                                             : irm_pkg::CMD_WRITE,
                                    8'($urandom_range(255)), 8'($urandom_range(255)),
                                    8'($urandom_range(0, 5)));
            return make_tick((roll < 92) ? irm_pkg::CMD_TICK : CMD_UNUSED);
        end
        if (roll < 4)
            return make_tick(CMD_UNUSED);
        if (roll < 8)
            return make_command(($urandom_range(1) != 0) ? irm_pkg::CMD_READ
                                                         : irm_pkg::CMD_WRITE,
                                8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255)));
        return make_tick(irm_pkg::CMD_TICK);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register write with the reset address and phase length: run into
        // the address byte, then shorten the phases to finish quickly.
        send_step(make_command(irm_pkg::CMD_WRITE, 8'hA5, 8'h3C, 8'h00));
        repeat (40) send_step(make_tick(irm_pkg::CMD_TICK));
        drain_results();
        write_setting(irm_pkg::CFG_PHASE_TICKS, 16'd1);
        tick_until_idle();

        // Shortest phases and the lowest address, with the field extremes.
        drain_results();
        write_setting(irm_pkg::CFG_DEVICE_ADDRESS, 16'd0);
        run_transaction(irm_pkg::CMD_WRITE, 8'h00, 8'hFF, 8'hFF);
        run_transaction(irm_pkg::CMD_WRITE, 8'hFF, 8'h00, 8'h00);
        // A zero read count reads a single byte.
        run_transaction(irm_pkg::CMD_READ, 8'hFF, 8'h00, 8'h00);
        run_transaction(irm_pkg::CMD_READ, 8'h5A, 8'hA5, 8'h01);
        // The unused code and a plain tick while idle start nothing.
        send_step(make_tick(CMD_UNUSED));
        send_step(make_tick(irm_pkg::CMD_TICK));

        // Highest address and a zero phase length, which counts as one.
        // Commands offered while busy only tick the sequencer.
        drain_results();
        write_setting(irm_pkg::CFG_DEVICE_ADDRESS, 16'd127);
        write_setting(irm_pkg::CFG_PHASE_TICKS, 16'd0);
        send_step(make_command(irm_pkg::CMD_READ, 8'h3C, 8'hC3, 8'h03));
        send_step(make_command(irm_pkg::CMD_WRITE, 8'h11, 8'h22, 8'h05));
        send_step(make_command(irm_pkg::CMD_READ, 8'h44, 8'h55, 8'h09));
        send_step(make_tick(CMD_UNUSED));
        tick_until_idle();

        // A burst read of several bytes.
        drain_results();
        write_setting(irm_pkg::CFG_PHASE_TICKS, 16'd1);
        run_transaction(irm_pkg::CMD_READ, 8'h81, 8'h7E, 8'h04);

        // Address changed in the middle of a read: the repeated start must
        // carry the new address.
        send_step(make_command(irm_pkg::CMD_READ, 8'h96, 8'h69, 8'h02));
        repeat (30) send_step(make_tick(irm_pkg::CMD_TICK));
        drain_results();
        write_setting(irm_pkg::CFG_DEVICE_ADDRESS, 16'h2B);
        tick_until_idle();

        // Longest phase length: run part way into the first phase, then
        // shorten it so the transaction finishes in reasonable time.
        drain_results();
        write_setting(irm_pkg::CFG_PHASE_TICKS, 16'hFFFF);
        send_step(make_command(irm_pkg::CMD_WRITE, 8'h0F, 8'hF0, 8'h00));
        repeat (100) send_step(make_tick(irm_pkg::CMD_TICK));
        drain_results();
        write_setting(irm_pkg::CFG_PHASE_TICKS, 16'd1);
        tick_until_idle();

        // Random traffic in six phases over the idling mixes, each with a
        // fresh address and a short phase length.
        for (int p = 0; p < 6; p++)
        begin
            drain_results();
            unique case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 49; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 49; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            write_setting(irm_pkg::CFG_DEVICE_ADDRESS,
                          (p == 0) ? 16'd0 : (p == 5) ? 16'd127 : 16'($urandom_range(127)));
            write_setting(irm_pkg::CFG_PHASE_TICKS, 16'($urandom_range(1, 3)));
            if (p == 0)
                hold_request = 1'b1;
            for (int n = 0; n < 50; n++)
                send_step(next_random_step());
        end
        tick_until_idle();

        drain_results();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
src/irm_pkg.sv
src/irm_front.sv
src/irm_queue.sv
src/irm_back.sv
src/i2c_register_master.sv
bench/tb_i2c_register_master.sv
